// ----- hw/rtl/rbu_pkg.sv -----
// Shared types, constants and the pixel blend function of the RGB565 4x upscaler.
`timescale 1ns / 1ps

package rbu_pkg;

    localparam int MaxWidth   = 256;
    localparam int MaxHeight  = 256;
    localparam int MinDim     = 2;
    localparam int QueueDepth = 2;

    localparam logic [8:0] WidthReset  = 9'd200;
    localparam logic [8:0] HeightReset = 9'd120;

    // Configuration register indexes.
    localparam logic CfgSourceWidth  = 1'b0;
    localparam logic CfgSourceHeight = 1'b1;

    // Sub-position within the 4x4 run: dy in the upper two bits, dx in the lower two.
    localparam logic [3:0] LastSub = 4'd15;

    // One complete 2x2 neighborhood with the base destination coordinates.
    typedef struct packed {
        logic [15:0] p00;
        logic [15:0] p01;
        logic [15:0] p10;
        logic [15:0] p11;
        logic [9:0]  bx;
        logic [9:0]  by;
    } job_t;

    function automatic logic [5:0] lerp_channel(
        input logic [5:0] a,
        input logic [5:0] b,
        input logic [5:0] c,
        input logic [5:0] d,
        input logic [1:0] dx,
        input logic [1:0] dy
    );
        logic [2:0] wx0;
        logic [2:0] wx1;
        logic [2:0] wy0;
        logic [2:0] wy1;
        logic [9:0] sum;
        wx0 = 3'd4 - {1'b0, dx};
        wx1 = {1'b0, dx};
        wy0 = 3'd4 - {1'b0, dy};
        wy1 = {1'b0, dy};
        sum = 10'(a) * 10'(wx0 * wy0) + 10'(b) * 10'(wx1 * wy0)
            + 10'(c) * 10'(wx0 * wy1) + 10'(d) * 10'(wx1 * wy1);
        return sum[9:4];
    endfunction

    function automatic logic [15:0] mix_pixel(
        input job_t       job,
        input logic [1:0] dx,
        input logic [1:0] dy
    );
        logic [5:0] r;
        logic [5:0] g;
        logic [5:0] b;
        r = lerp_channel({1'b0, job.p00[15:11]}, {1'b0, job.p01[15:11]},
                         {1'b0, job.p10[15:11]}, {1'b0, job.p11[15:11]}, dx, dy);
        g = lerp_channel(job.p00[10:5], job.p01[10:5], job.p10[10:5], job.p11[10:5], dx, dy);
        b = lerp_channel({1'b0, job.p00[4:0]}, {1'b0, job.p01[4:0]},
                         {1'b0, job.p10[4:0]}, {1'b0, job.p11[4:0]}, dx, dy);
        return {r[4:0], g, b[4:0]};
    endfunction

endpackage

// ----- hw/rtl/rbu_front.sv -----
// Front end: source pixel intake, line buffer, raster counters and job generation.
`timescale 1ns / 1ps

module rbu_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [15:0]   s_tdata,
    input  logic          cfg_valid,
    input  logic          cfg_index,
    input  logic [8:0]    cfg_data,
    input  logic          q_full,
    output logic          push_valid,
    output rbu_pkg::job_t push_job
);

    typedef enum logic [1:0] {
        F_READ = 2'b01,
        F_TAKE = 2'b10
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [8:0]  width_cfg_reg;
    logic [8:0]  height_cfg_reg;
    logic [7:0]  col_reg, col_next;
    logic [7:0]  row_reg, row_next;
    logic [15:0] left_reg;
    logic [15:0] upper_left_reg;
    logic [15:0] above_reg;
    logic [15:0] row_mem [rbu_pkg::MaxWidth];

    logic [8:0] width_eff;
    logic [8:0] height_eff;
    logic       accept;
    logic       rd_en;

    assign width_eff  = (width_cfg_reg < 9'(rbu_pkg::MinDim))   ? 9'(rbu_pkg::MinDim)   :
                        (width_cfg_reg > 9'(rbu_pkg::MaxWidth))  ? 9'(rbu_pkg::MaxWidth)  :
                        width_cfg_reg;
    assign height_eff = (height_cfg_reg < 9'(rbu_pkg::MinDim))  ? 9'(rbu_pkg::MinDim)   :
                        (height_cfg_reg > 9'(rbu_pkg::MaxHeight)) ? 9'(rbu_pkg::MaxHeight) :
                        height_cfg_reg;

    assign s_tready = (state_reg == F_TAKE) && !q_full;
    assign accept   = s_tvalid && s_tready;
    assign rd_en    = (state_reg == F_READ);

    assign push_valid   = accept && (col_reg != 8'd0) && (row_reg != 8'd0);
    assign push_job.p00 = upper_left_reg;
    assign push_job.p01 = above_reg;
    assign push_job.p10 = left_reg;
    assign push_job.p11 = s_tdata;
    assign push_job.bx  = {col_reg - 8'd1, 2'b00};
    assign push_job.by  = {row_reg - 8'd1, 2'b00};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_READ: state_next = F_TAKE;
            F_TAKE: begin
                if (accept) begin
                    state_next = F_READ;
                end
            end
            default: state_next = F_READ;
        endcase
    end

    // A counter left beyond a shrunk bound wraps at its next advance.
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if ({1'b0, col_reg} + 9'd1 >= width_eff) begin
                col_next = 8'd0;
                row_next = ({1'b0, row_reg} + 9'd1 >= height_eff) ? 8'd0 : row_reg + 8'd1;
            end else begin
                col_next = col_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= F_READ;
            width_cfg_reg  <= rbu_pkg::WidthReset;
            height_cfg_reg <= rbu_pkg::HeightReset;
            col_reg        <= 8'd0;
            row_reg        <= 8'd0;
            left_reg       <= 16'd0;
            upper_left_reg <= 16'd0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            if (cfg_valid) begin
                case (cfg_index)
                    rbu_pkg::CfgSourceWidth:  width_cfg_reg  <= cfg_data;
                    rbu_pkg::CfgSourceHeight: height_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                left_reg       <= s_tdata;
                upper_left_reg <= above_reg;
            end
        end
    end

    // Line buffer: read the entry above in the read state, overwrite it on intake.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            above_reg <= row_mem[col_reg];
        end
        if (accept) begin
            row_mem[col_reg] <= s_tdata;
        end
    end

endmodule

// ----- hw/rtl/rbu_queue.sv -----
// Short job queue between the front end and the interpolation back end.
`timescale 1ns / 1ps

module rbu_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    input  rbu_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          pop_valid,
    output rbu_pkg::job_t pop_job
);

    localparam int PtrW = $clog2(rbu_pkg::QueueDepth);
    localparam int CntW = $clog2(rbu_pkg::QueueDepth + 1);

    rbu_pkg::job_t    slot_reg [rbu_pkg::QueueDepth];
    logic [PtrW-1:0]  wr_ptr_reg;
    logic [PtrW-1:0]  rd_ptr_reg;
    logic [CntW-1:0]  count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CntW'(rbu_pkg::QueueDepth));
    assign pop_valid = (count_reg != '0);
    assign pop_job   = slot_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(rbu_pkg::QueueDepth - 1)) ? '0
                                                                             : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(rbu_pkg::QueueDepth - 1)) ? '0
                                                                             : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- hw/rtl/rbu_back.sv -----
// Back end: walks each job through its 4x4 run and registers one blended pixel a cycle unless stalled.
`timescale 1ns / 1ps

module rbu_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  rbu_pkg::job_t q_job,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [39:0]   m_tdata,
    output logic          m_tlast
);

    rbu_pkg::job_t job_reg;
    logic          busy_reg;
    logic [3:0]    sub_reg;
    logic          m_valid_reg;
    logic [15:0]   pix_reg;
    logic [9:0]    x_reg;
    logic [9:0]    y_reg;
    logic          last_reg;
    logic          advance;

    assign advance = !m_valid_reg || m_tready;
    assign q_pop   = q_valid && (!busy_reg || (advance && sub_reg == rbu_pkg::LastSub));

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, y_reg, x_reg, pix_reg};
    assign m_tlast  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            sub_reg     <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                m_valid_reg <= busy_reg;
            end
            if (advance && busy_reg) begin
                sub_reg <= sub_reg + 4'd1;
                if (sub_reg == rbu_pkg::LastSub) begin
                    busy_reg <= 1'b0;
                end
            end
            // A new job can start in the cycle the previous run registers its last pixel.
            if (q_pop) begin
                busy_reg <= 1'b1;
                sub_reg  <= 4'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_job;
        end
        if (advance && busy_reg) begin
            pix_reg  <= rbu_pkg::mix_pixel(job_reg, sub_reg[1:0], sub_reg[3:2]);
            x_reg    <= job_reg.bx + {8'd0, sub_reg[1:0]};
            y_reg    <= job_reg.by + {8'd0, sub_reg[3:2]};
            last_reg <= (sub_reg == rbu_pkg::LastSub);
        end
    end

    a_pop_only_at_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (!busy_reg || sub_reg == rbu_pkg::LastSub))
        else $error("job popped in the middle of a run");

    a_last_at_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && last_reg) |-> (x_reg[1:0] == 2'b11 && y_reg[1:0] == 2'b11))
        else $error("run end flagged away from the bottom-right sub-pixel");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && sub_reg != 4'd0) |-> $past(busy_reg))
        else $error("run position advanced without an active job");

endmodule

// ----- hw/rtl/rgb565_bilinear_upscale_x4_unit.sv -----
// Top level of the RGB565 bilinear 4x upscaler.
`timescale 1ns / 1ps

// Source pixels arrive in raster order on the s_ stream and blended destination pixels
// leave on the m_ stream, sixteen per source pixel that completes a 2x2 neighborhood (every
// pixel from row 1 and column 1 on), in row-major order of the 4x4 run, with tlast on the
// sixteenth. Pixels of the first row or column update the line buffer and yield nothing.
// The front end alternates a read state, which reads the line buffer entry above, and a take
// state, which accepts the pixel and writes that entry while the job queue is not full. The
// back end emits one result per cycle from its output register while m_tready allows; a
// two-entry job queue lets the front keep accepting while a run drains. Width and height
// are saturated to 2..256; writes through the cfg port (index 0 width, 1 height) take
// effect at once and are always accepted.
module rgb565_bilinear_upscale_x4_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // in_pixel[15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_pixel[15:0], out_x[25:16], out_y[35:26], zero pad
    output logic        m_tlast,   // run_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    logic          push_valid;
    rbu_pkg::job_t push_job;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    rbu_pkg::job_t q_job;

    assign cfg_ready = 1'b1;

    rbu_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    rbu_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_job    (q_job)
    );

    rbu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the RGB565 bilinear 4x upscaler.
`timescale 1ns / 1ps

module testbench;

    localparam int CycleLimit  = 500_000;
    localparam int SettleWait  = 40;
    localparam int LongHoldOff = 300;
    localparam int RandomItems = 90;

    typedef struct packed {
        logic [15:0] pixel;
        logic [9:0]  x;
        logic [9:0]  y;
        logic        last;
    } dst_pixel_t;

    typedef struct packed {
        logic        is_cfg;
        logic        reg_sel;
        logic [15:0] value;
        logic        typed;
        logic [15:0] typed_pixel;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [8:0]  cfg_data;

    rgb565_bilinear_upscale_x4_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Directed part. Pixel rows whose whole neighborhood is one color carry that color
    // as the typed expectation for all sixteen results.
    stim_row_t directed_rows [24] = '{
        '{1'b1, rbu_pkg::CfgSourceWidth,  16'd1,    1'b0, 16'h0000},
        '{1'b1, rbu_pkg::CfgSourceHeight, 16'd0,    1'b0, 16'h0000},
        '{1'b0, 1'b0,                     16'hFFFF, 1'b0, 16'h0000},
        '{1'b0, 1'b0,                     16'hFFFF, 1'b0, 16'h0000},
        '{1'b0, 1'b0,                     16'hFFFF, 1'b0, 16'h0000},
        '{1'b0, 1'b0,                     16'hFFFF, 1'b1, 16'hFFFF},
        '{1'b0, 1'b0,                     16'h0000, 1'b0, 16'h0000},
        '{1'b0, 1'b0,                     16'h0000, 1'b0, 16'h0000},
        '{1'b0, 1'b0,                     16'h0000, 1'b0, 16'h0000},
        '{1'b0, 1'b0,                     16'h0000, 1'b1, 16'h0000},
        '{1'b1, rbu_pkg::CfgSourceWidth,  16'd3,    1'b0, 16'h0000},
        '{1'b1, rbu_pkg::CfgSourceHeight, 16'd300,  1'b0, 16'h0000},
        '{1'b0, 1'b0,                     16'hF800, 1'b0, 16'h0000},
        '{1'b0, 1'b0,                     16'h07E0, 1'b0, 16'h0000},
        '{1'b0, 1'b0,                     16'h001F, 1'b0, 16'h0000},
        '{1'b0, 1'b0,                     16'h0000, 1'b0, 16'h0000},
        '{1'b0, 1'b0,                     16'hFFFF, 1'b0, 16'h0000},
        '{1'b1, rbu_pkg::CfgSourceWidth,  16'd2,    1'b0, 16'h0000},
        '{1'b0, 1'b0,                     16'h1234, 1'b0, 16'h0000},
        '{1'b0, 1'b0,                     16'hABCD, 1'b0, 16'h0000},
        '{1'b0, 1'b0,                     16'h5555, 1'b0, 16'h0000},
        '{1'b1, rbu_pkg::CfgSourceHeight, 16'd2,    1'b0, 16'h0000},
        '{1'b0, 1'b0,                     16'hAAAA, 1'b0, 16'h0000},
        '{1'b0, 1'b0,                     16'h8421, 1'b0, 16'h0000}
    };

    // Shadow state of the upscaler.
    logic [15:0] line_buf   [rbu_pkg::MaxWidth];
    bit          line_known [rbu_pkg::MaxWidth];
    logic [15:0] left_px;
    logic [15:0] upleft_px;
    int unsigned col_cnt;
    int unsigned row_cnt;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;

    dst_pixel_t  expected_pixels [$];
    int          error_count;
    int          cycle_count;
    int          burst_left;
    bit          hold_request;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned got_v,
                                   input int unsigned want_v);
        if (error_count < 100)
            $display("%s mismatch: got 0x%0h, expected 0x%0h", what, got_v, want_v);
        error_count++;
    endtask

    function automatic int unsigned clamp_dim(input logic [8:0] raw, input int hi);
        if (raw < rbu_pkg::MinDim)
            return rbu_pkg::MinDim;
        if (raw > hi)
            return hi;
        return raw;
    endfunction

    function automatic logic [15:0] blend_565(input logic [15:0] p00, input logic [15:0] p01,
                                             input logic [15:0] p10, input logic [15:0] p11,
                                             input int dx, input int dy);
        int w00;
        int w01;
        int w10;
        int w11;
        int r;
        int g;
        int b;
        w00 = (4 - dx) * (4 - dy);
        w01 = dx * (4 - dy);
        w10 = (4 - dx) * dy;
        w11 = dx * dy;
        r = (int'(p00[15:11]) * w00 + int'(p01[15:11]) * w01
           + int'(p10[15:11]) * w10 + int'(p11[15:11]) * w11) >> 4;
        g = (int'(p00[10:5]) * w00 + int'(p01[10:5]) * w01
           + int'(p10[10:5]) * w10 + int'(p11[10:5]) * w11) >> 4;
        b = (int'(p00[4:0]) * w00 + int'(p01[4:0]) * w01
           + int'(p10[4:0]) * w10 + int'(p11[4:0]) * w11) >> 4;
        return {5'(r), 6'(g), 5'(b)};
    endfunction

    // Advances the shadow state by one source pixel and queues the 4x4 run it completes.
    task automatic upscale_pixel(input logic [15:0] px, input bit use_typed,
                                 input logic [15:0] typed_px);
        logic [15:0] above;
        dst_pixel_t  res;
        above = line_buf[col_cnt];
        if (col_cnt >= 1 && row_cnt >= 1) begin
            for (int dy = 0; dy < 4; dy++) begin
                for (int dx = 0; dx < 4; dx++) begin
                    res.pixel = use_typed ? typed_px
                                          : blend_565(upleft_px, above, left_px, px, dx, dy);
                    res.x     = 10'((col_cnt - 1) * 4 + dx);
                    res.y     = 10'((row_cnt - 1) * 4 + dy);
                    res.last  = (dx == 3 && dy == 3);
                    expected_pixels.push_back(res);
                end
            end
        end
        upleft_px = above;
        line_buf[col_cnt] = px;
        line_known[col_cnt] = 1'b1;
        left_px = px;
        if (col_cnt + 1 >= clamp_dim(width_reg, rbu_pkg::MaxWidth)) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= clamp_dim(height_reg, rbu_pkg::MaxHeight)) ? 0
                                                                                   : row_cnt + 1;
        end else begin
            col_cnt = col_cnt + 1;
        end
    endtask

    // Called right after the clock rises; returns once the pixel has been accepted.
    task automatic send_pixel(input logic [15:0] px, input bit use_typed,
                              input logic [15:0] typed_px);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        upscale_pixel(px, use_typed, typed_px);
        burst_left--;
    endtask

    task automatic pause_stream();
        s_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    // Waits until every queued result has been seen, then lets any pixel that
    // yields nothing clear the pipeline.
    task automatic wait_drain();
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (SettleWait) @(posedge aclk);
    endtask

    // Leaves cfg_valid high so back-to-back writes need no toggle; the caller lowers it.
    task automatic write_reg(input logic sel, input logic [8:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (sel == rbu_pkg::CfgSourceWidth)
            width_reg = val;
        else
            height_reg = val;
    endtask

    function automatic logic [15:0] random_pixel();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [8:0] random_dim(input int small_hi);
        case ($urandom_range(0, 9))
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd2;
            3:       return 9'd256;
            4:       return 9'($urandom_range(257, 511));
            default: return 9'($urandom_range(3, small_hi));
        endcase
    endfunction

    // Receiver: random ready pattern in stretches, plus one long hold-off on request.
    initial begin
        int hold_cnt;
        int mode_left;
        int ready_pct;
        bit hold_done;
        hold_cnt  = 0;
        mode_left = 0;
        ready_pct = 100;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_done) begin
                hold_cnt  = LongHoldOff;
                hold_done = 1'b1;
            end
            if (hold_cnt > 0) begin
                m_tready <= 1'b0;
                hold_cnt--;
            end else begin
                if (mode_left == 0) begin
                    case ($urandom_range(0, 3))
                        0:       ready_pct = 100;
                        1:       ready_pct = 75;
                        2:       ready_pct = 40;
                        default: ready_pct = 15;
                    endcase
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                m_tready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        dst_pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[15:0], 0);
            end else begin
                want = expected_pixels.pop_front();
                if (m_tdata[15:0] !== want.pixel)
                    report_mismatch("pixel", m_tdata[15:0], want.pixel);
                if (m_tdata[25:16] !== want.x)
                    report_mismatch("x", m_tdata[25:16], want.x);
                if (m_tdata[35:26] !== want.y)
                    report_mismatch("y", m_tdata[35:26], want.y);
                if (m_tlast !== want.last)
                    report_mismatch("tlast", m_tlast, want.last);
            end
        end
    end

    initial begin
        stim_row_t   row;
        bit          cfg_open;
        int          random_sent;
        int          phase;
        int          items;
        int          known_prefix;
        int          which;
        logic [8:0]  new_width;
        logic [8:0]  new_height;

        error_count  = 0;
        cycle_count  = 0;
        burst_left   = 0;
        hold_request = 1'b0;
        cfg_open     = 1'b0;
        random_sent  = 0;
        left_px      = 16'h0000;
        upleft_px    = 16'h0000;
        col_cnt      = 0;
        row_cnt      = 0;
        width_reg    = rbu_pkg::WidthReset;
        height_reg   = rbu_pkg::HeightReset;
        for (int i = 0; i < rbu_pkg::MaxWidth; i++) begin
            line_buf[i]   = 16'h0000;
            line_known[i] = 1'b0;
        end

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 16'h0000;
        cfg_valid <= 1'b0;
        cfg_index <= rbu_pkg::CfgSourceWidth;
        cfg_data  <= 9'd0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < $size(directed_rows); i++) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                if (!cfg_open) begin
                    pause_stream();
                    wait_drain();
                    cfg_open = 1'b1;
                end
                write_reg(row.reg_sel, row.value[8:0]);
            end else begin
                if (cfg_open) begin
                    cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_pixel(row.value, row.typed, row.typed_pixel);
            end
        end

        // Random phases. The first runs at the widest setting along part of row 0; a width
        // raised mid-frame is held to the entries of the line buffer already written.
        phase = 0;
        while (random_sent < RandomItems || phase < 3) begin
            pause_stream();
            wait_drain();
            known_prefix = 0;
            while (known_prefix < rbu_pkg::MaxWidth && line_known[known_prefix])
                known_prefix++;
            if (phase == 0) begin
                new_width  = 9'd511;
                new_height = 9'($urandom_range(2, 4));
                which      = 2;
                items      = $urandom_range(8, 16);
            end else if (phase == 2) begin
                // Short rows make every pixel of column 1 from row 1 on produce, so the long hold-off
                // backs up into the input.
                new_width  = 9'd2;
                new_height = 9'd6;
                which      = 2;
                items      = 24;
            end else begin
                new_width  = random_dim(12);
                new_height = random_dim(6);
                which      = $urandom_range(0, 2);
                items      = $urandom_range(8, 24);
            end
            if (row_cnt != 0 && clamp_dim(new_width, rbu_pkg::MaxWidth) > known_prefix)
                new_width = 9'(known_prefix);
            if (which != 1)
                write_reg(rbu_pkg::CfgSourceWidth, new_width);
            if (which != 0)
                write_reg(rbu_pkg::CfgSourceHeight, new_height);
            cfg_valid <= 1'b0;
            for (int k = 0; k < items; k++) begin
                if (phase == 2 && k == 0)
                    hold_request = 1'b1;
                send_pixel(random_pixel(), 1'b0, 16'h0000);
            end
            random_sent += items;
            phase++;
        end

        pause_stream();
        wait_drain();
        if (expected_pixels.size() != 0)
            report_mismatch("leftover results", expected_pixels.size(), 0);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/rbu_pkg.sv
hw/rtl/rbu_front.sv
hw/rtl/rbu_queue.sv
hw/rtl/rbu_back.sv
hw/rtl/rgb565_bilinear_upscale_x4_unit.sv
tb/testbench.sv
